@@ rtl/htda_pkg.sv @@
// Shared constants, types and widths for the harmonic tremolo delay/allpass block.
// Depends on nothing; the top level imports it.
package htda_pkg;

    // Delay line and sample format
    localparam int DELAY_DEPTH = 512;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_BITS   = $clog2(DELAY_DEPTH);
    localparam int FILL_BITS   = ADDR_BITS + 1;
    localparam int FRAC_BITS   = 8;
    localparam int DLY_BITS    = ADDR_BITS + FRAC_BITS;
    localparam int DMAX        = (DELAY_DEPTH - 2) * 256;

    // Allpass cascade
    localparam int STAGE_BITS  = SAMPLE_BITS + 2;
    localparam int NUM_STAGES  = 4;
    localparam int STG_BITS    = $clog2(NUM_STAGES);

    // Configuration port
    localparam int NUM_REGS    = 7;
    localparam int PADDR_BITS  = $clog2(NUM_REGS * 4);
    localparam int CFG_BITS    = 17;
    localparam int LFO_BITS    = 16;

    // Shared multiplier operand and product widths
    localparam int MA_BITS     = (SAMPLE_BITS + 3 > 34) ? SAMPLE_BITS + 3 : 34;
    localparam int MB_BITS     = CFG_BITS + 1;
    localparam int PROD_BITS   = MA_BITS + MB_BITS;
    localparam int SWING_SHIFT = 31;
    localparam int SWING_BITS  = PROD_BITS - SWING_SHIFT;
    localparam int DW          = SWING_BITS + 1;
    localparam int COEF_SHIFT  = 16;
    localparam int YW          = PROD_BITS - COEF_SHIFT + 1;

    // Saturation bounds
    localparam logic signed [DW-1:0] DMAX_W = DW'(DMAX);
    localparam logic signed [YW-1:0] Y_HI   = YW'((64'sd1 <<< (STAGE_BITS - 1)) - 64'sd1);
    localparam logic signed [YW-1:0] Y_LO   = -Y_HI - YW'(1);
    localparam logic signed [STAGE_BITS-1:0] O_HI =
        STAGE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [STAGE_BITS-1:0] O_LO = -O_HI - STAGE_BITS'(1);

    // Register reset values
    localparam logic [CFG_BITS-1:0] MOD_DEPTH_RST  = CFG_BITS'(32768);
    localparam logic [CFG_BITS-1:0] BASE_DELAY_RST = CFG_BITS'(24576);
    localparam logic [CFG_BITS-1:0] DELAY_SPAN_RST = CFG_BITS'(18432);
    localparam logic [CFG_BITS-1:0] COEF_A_RST     = CFG_BITS'(-63844);
    localparam logic [CFG_BITS-1:0] COEF_B_RST     = CFG_BITS'(-61381);
    localparam logic [CFG_BITS-1:0] COEF_C_RST     = CFG_BITS'(-55975);
    localparam logic [CFG_BITS-1:0] COEF_D_RST     = CFG_BITS'(-43792);

    // Register map
    typedef enum logic [PADDR_BITS-3:0] {
        REG_MOD_DEPTH  = 3'd0,
        REG_BASE_DELAY = 3'd1,
        REG_DELAY_SPAN = 3'd2,
        REG_COEF_A     = 3'd3,
        REG_COEF_B     = 3'd4,
        REG_COEF_C     = 3'd5,
        REG_COEF_D     = 3'd6
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWING_A,
        ST_SWING_B,
        ST_DELAY,
        ST_TAP_A,
        ST_TAP_B,
        ST_TAP_C,
        ST_INTERP,
        ST_WET,
        ST_STAGE_MUL,
        ST_STAGE_ACC,
        ST_OUT
    } state_t;

endpackage

@@ rtl/harmonic_tremolo_delay_allpass_top.sv @@
// Harmonic tremolo core: modulated fractional delay, four allpass stages, dry mix.
// Depends on htda_pkg (constants, state and register types) and htda_ram.
//
// Usage:
//   Input channel (in_valid/in_ready, audio_in, lfo_value) takes one word per
//   sample; output channel (out_valid/out_ready, audio_out) returns one word
//   for each input word, in order. The user must write the registers over
//   the APB port (mod_depth, base_delay, delay_span, coef_stage_a..d at 4*i)
//   only while idle; the block itself does not enforce this. The sequencer
//   walks one word at a time through a shared 34x18 multiplier (two swing
//   products, one tap interpolation, one per allpass stage) and a single
//   read port on the delay RAM (two taps read back to back).
//   The output register holds a finished word while the next input word is
//   taken and processed; if the receiver still stalls when that next word is
//   done, the sequencer waits in its output state.
//   Reset: registers take their default values, delay line and allpass state
//   read as zero. No clearing pass: a fill count marks which delay entries
//   were written, valid bits mark the allpass state entries.
module harmonic_tremolo_delay_allpass_top (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // input words
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [htda_pkg::SAMPLE_BITS-1:0]   audio_in,
    input  logic signed [htda_pkg::LFO_BITS-1:0]      lfo_value,
    // output words
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [htda_pkg::SAMPLE_BITS-1:0]   audio_out,
    // configuration
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [htda_pkg::PADDR_BITS-1:0]           paddr,
    input  logic [31:0]                               pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    import htda_pkg::*;

    // Configuration registers
    logic [CFG_BITS-1:0]        mod_depth_reg;
    logic [CFG_BITS-1:0]        base_delay_reg;
    logic [CFG_BITS-1:0]        delay_span_reg;
    logic signed [CFG_BITS-1:0] coef_a_reg;
    logic signed [CFG_BITS-1:0] coef_b_reg;
    logic signed [CFG_BITS-1:0] coef_c_reg;
    logic signed [CFG_BITS-1:0] coef_d_reg;
    reg_idx_t                   cfg_idx;
    logic                       cfg_we;

    // Control state
    state_t                     state_reg;
    state_t                     state_next;
    logic [ADDR_BITS-1:0]       wi_reg;
    logic [FILL_BITS-1:0]       fill_reg;
    logic [STG_BITS-1:0]        stage_reg;
    logic [STG_BITS-1:0]        stage_next;
    logic [NUM_STAGES-1:0]      st_valid_reg;
    logic                       st_rvalid_reg;
    logic                       out_valid_reg;

    // Datapath registers
    logic signed [SAMPLE_BITS-1:0] dry_reg;
    logic signed [LFO_BITS-1:0]    lfo_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic [ADDR_BITS-1:0]          dint_reg;
    logic [FRAC_BITS-1:0]          frac_reg;
    logic [ADDR_BITS-1:0]          pos1_reg;
    logic signed [SAMPLE_BITS-1:0] s1_reg;
    logic signed [SAMPLE_BITS-1:0] s2_reg;
    logic signed [STAGE_BITS-1:0]  wet_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;

    // Sequencer outputs
    logic                          dram_we;
    logic [ADDR_BITS-1:0]          dram_raddr;
    logic [SAMPLE_BITS-1:0]        dram_rdata;
    logic                          st_we;
    logic [STG_BITS-1:0]           st_raddr;
    logic [2*STAGE_BITS-1:0]       st_rdata;
    logic signed [MA_BITS-1:0]     mul_a;
    logic signed [MB_BITS-1:0]     mul_b;
    logic                          out_load;

    // Combinational datapath
    logic signed [SWING_BITS-1:0]  swing;
    logic signed [DW-1:0]          d_wide;
    logic [DLY_BITS-1:0]           d_sat;
    logic [ADDR_BITS-1:0]          pos1;
    logic [ADDR_BITS-1:0]          pos2;
    logic                          tap1_ok;
    logic                          tap2_ok;
    logic signed [SAMPLE_BITS:0]   tap_diff;
    logic signed [STAGE_BITS-1:0]  x1;
    logic signed [STAGE_BITS-1:0]  y1;
    logic signed [STAGE_BITS:0]    st_diff;
    logic signed [CFG_BITS-1:0]    coef;
    logic signed [YW-1:0]          y_wide;
    logic signed [STAGE_BITS-1:0]  y_sat;
    logic signed [STAGE_BITS-1:0]  wet_next;
    logic signed [STAGE_BITS:0]    mix_sum;
    logic signed [STAGE_BITS-1:0]  mix_half;
    logic signed [SAMPLE_BITS-1:0] mix_sat;

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_BITS-1:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_depth_reg  <= MOD_DEPTH_RST;
            base_delay_reg <= BASE_DELAY_RST;
            delay_span_reg <= DELAY_SPAN_RST;
            coef_a_reg     <= COEF_A_RST;
            coef_b_reg     <= COEF_B_RST;
            coef_c_reg     <= COEF_C_RST;
            coef_d_reg     <= COEF_D_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_MOD_DEPTH:  mod_depth_reg  <= pwdata[CFG_BITS-1:0];
                REG_BASE_DELAY: base_delay_reg <= pwdata[CFG_BITS-1:0];
                REG_DELAY_SPAN: delay_span_reg <= pwdata[CFG_BITS-1:0];
                REG_COEF_A:     coef_a_reg     <= pwdata[CFG_BITS-1:0];
                REG_COEF_B:     coef_b_reg     <= pwdata[CFG_BITS-1:0];
                REG_COEF_C:     coef_c_reg     <= pwdata[CFG_BITS-1:0];
                REG_COEF_D:     coef_d_reg     <= pwdata[CFG_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_MOD_DEPTH:  prdata[CFG_BITS-1:0] = mod_depth_reg;
            REG_BASE_DELAY: prdata[CFG_BITS-1:0] = base_delay_reg;
            REG_DELAY_SPAN: prdata[CFG_BITS-1:0] = delay_span_reg;
            REG_COEF_A:     prdata[CFG_BITS-1:0] = coef_a_reg;
            REG_COEF_B:     prdata[CFG_BITS-1:0] = coef_b_reg;
            REG_COEF_C:     prdata[CFG_BITS-1:0] = coef_c_reg;
            REG_COEF_D:     prdata[CFG_BITS-1:0] = coef_d_reg;
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------------
    // Delay line: the new sample is written on accept, taps are read
    // afterwards in the tap states, so a zero delay sees the fresh sample.
    htda_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (dram_we),
        .waddr (wi_reg),
        .wdata (audio_in),
        .raddr (dram_raddr),
        .rdata (dram_rdata)
    );

    // Allpass state {prev_in, prev_out}: read address runs one stage ahead
    // of the write, so the two never hit the same entry.
    htda_ram #(
        .WIDTH (2 * STAGE_BITS),
        .DEPTH (NUM_STAGES)
    ) u_stage_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (stage_reg),
        .wdata ({wet_reg, y_sat}),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // ---------------------------------------------------------------------
    // Datapath arithmetic
    // ---------------------------------------------------------------------
    // Modulated delay: base + floor(lfo*depth*span / 2^31), clamp to range
    assign swing  = prod_reg[PROD_BITS-1:SWING_SHIFT];
    assign d_wide = {swing[SWING_BITS-1], swing}
                  + {{(DW-CFG_BITS){1'b0}}, base_delay_reg};

    always_comb
    begin
        priority if (d_wide[DW-1])
        begin
            d_sat = '0;
        end
        else if (d_wide > DMAX_W)
        begin
            d_sat = DLY_BITS'(DMAX);
        end
        else
        begin
            d_sat = d_wide[DLY_BITS-1:0];
        end
    end

    // Tap addresses, wrapped around the delay line
    assign pos1    = wi_reg - dint_reg + ADDR_BITS'(DELAY_DEPTH);
    assign pos2    = (pos1_reg == '0) ? ADDR_BITS'(DELAY_DEPTH - 1)
                                      : pos1_reg - ADDR_BITS'(1);
    // Entries not yet written since reset read as zero
    assign tap1_ok = {1'b0, dint_reg} < fill_reg;
    assign tap2_ok = ({1'b0, dint_reg} + FILL_BITS'(1)) < fill_reg;

    // Interpolation: s1 + floor(f*(s2-s1)/256)
    assign tap_diff = {s2_reg[SAMPLE_BITS-1], s2_reg} - {s1_reg[SAMPLE_BITS-1], s1_reg};
    assign wet_next = {{(STAGE_BITS-SAMPLE_BITS){s1_reg[SAMPLE_BITS-1]}}, s1_reg}
                    + prod_reg[STAGE_BITS+FRAC_BITS-1:FRAC_BITS];

    // Allpass stage: y = floor(c*(x - y1) / 2^16) + x1, saturated
    assign x1      = st_rvalid_reg ? st_rdata[2*STAGE_BITS-1:STAGE_BITS] : '0;
    assign y1      = st_rvalid_reg ? st_rdata[STAGE_BITS-1:0] : '0;
    assign st_diff = {wet_reg[STAGE_BITS-1], wet_reg} - {y1[STAGE_BITS-1], y1};
    assign y_wide  = {prod_reg[PROD_BITS-1], prod_reg[PROD_BITS-1:COEF_SHIFT]}
                   + {{(YW-STAGE_BITS){x1[STAGE_BITS-1]}}, x1};

    always_comb
    begin
        priority if (y_wide > Y_HI)
        begin
            y_sat = Y_HI[STAGE_BITS-1:0];
        end
        else if (y_wide < Y_LO)
        begin
            y_sat = Y_LO[STAGE_BITS-1:0];
        end
        else
        begin
            y_sat = y_wide[STAGE_BITS-1:0];
        end
    end

    // Select the coefficient of the active stage
    always_comb
    begin
        unique case (stage_reg)
            2'd0:    coef = coef_a_reg;
            2'd1:    coef = coef_b_reg;
            2'd2:    coef = coef_c_reg;
            default: coef = coef_d_reg;
        endcase
    end

    // Dry/wet half sum, saturated to the sample range
    assign mix_sum  = {{(STAGE_BITS+1-SAMPLE_BITS){dry_reg[SAMPLE_BITS-1]}}, dry_reg}
                    + {wet_reg[STAGE_BITS-1], wet_reg};
    assign mix_half = mix_sum[STAGE_BITS:1];

    always_comb
    begin
        priority if (mix_half > O_HI)
        begin
            mix_sat = O_HI[SAMPLE_BITS-1:0];
        end
        else if (mix_half < O_LO)
        begin
            mix_sat = O_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            mix_sat = mix_half[SAMPLE_BITS-1:0];
        end
    end

    // Shared multiplier
    assign prod_next = mul_a * mul_b;

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_SWING_A;
            ST_SWING_A:   state_next = ST_SWING_B;
            ST_SWING_B:   state_next = ST_DELAY;
            ST_DELAY:     state_next = ST_TAP_A;
            ST_TAP_A:     state_next = ST_TAP_B;
            ST_TAP_B:     state_next = ST_TAP_C;
            ST_TAP_C:     state_next = ST_INTERP;
            ST_INTERP:    state_next = ST_WET;
            ST_WET:       state_next = ST_STAGE_MUL;
            ST_STAGE_MUL: state_next = ST_STAGE_ACC;
            ST_STAGE_ACC:
            begin
                if (stage_reg == STG_BITS'(NUM_STAGES - 1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_STAGE_MUL;
                end
            end
            ST_OUT:       if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, memory control, multiplier operands
    always_comb
    begin
        in_ready   = 1'b0;
        dram_we    = 1'b0;
        dram_raddr = pos1_reg;
        st_we      = 1'b0;
        stage_next = stage_reg;
        mul_a      = '0;
        mul_b      = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                dram_we  = in_valid;
            end
            ST_SWING_A:
            begin
                mul_a = {{(MA_BITS-LFO_BITS){lfo_reg[LFO_BITS-1]}}, lfo_reg};
                mul_b = {1'b0, mod_depth_reg};
            end
            ST_SWING_B:
            begin
                mul_a = prod_reg[MA_BITS-1:0];
                mul_b = {1'b0, delay_span_reg};
            end
            ST_TAP_A:
            begin
                dram_raddr = pos1;
            end
            ST_TAP_B:
            begin
                dram_raddr = pos2;
            end
            ST_INTERP:
            begin
                mul_a = {{(MA_BITS-SAMPLE_BITS-1){tap_diff[SAMPLE_BITS]}}, tap_diff};
                mul_b = {{(MB_BITS-FRAC_BITS){1'b0}}, frac_reg};
            end
            ST_STAGE_MUL:
            begin
                mul_a = {{(MA_BITS-STAGE_BITS-1){st_diff[STAGE_BITS]}}, st_diff};
                mul_b = {coef[CFG_BITS-1], coef};
            end
            ST_STAGE_ACC:
            begin
                st_we = 1'b1;
                if (stage_reg == STG_BITS'(NUM_STAGES - 1))
                begin
                    stage_next = '0;
                end
                else
                begin
                    stage_next = stage_reg + STG_BITS'(1);
                end
            end
            ST_OUT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default: ;
        endcase
    end

    assign st_raddr = stage_next;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wi_reg        <= '0;
            fill_reg      <= '0;
            stage_reg     <= '0;
            st_valid_reg  <= '0;
            st_rvalid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            st_rvalid_reg <= st_valid_reg[st_raddr];
            // count written delay entries, hold at full
            if (dram_we && (fill_reg != FILL_BITS'(DELAY_DEPTH)))
            begin
                fill_reg <= fill_reg + FILL_BITS'(1);
            end
            if (st_we)
            begin
                st_valid_reg[stage_reg] <= 1'b1;
            end
            // advance the write index once the word is done
            if (out_load)
            begin
                if (wi_reg == ADDR_BITS'(DELAY_DEPTH - 1))
                begin
                    wi_reg <= '0;
                end
                else
                begin
                    wi_reg <= wi_reg + ADDR_BITS'(1);
                end
            end
            // hold the output word until taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (dram_we)
        begin
            dry_reg <= audio_in;
            lfo_reg <= lfo_value;
        end
        if (state_reg == ST_DELAY)
        begin
            dint_reg <= d_sat[DLY_BITS-1:FRAC_BITS];
            frac_reg <= d_sat[FRAC_BITS-1:0];
        end
        if (state_reg == ST_TAP_A)
        begin
            pos1_reg <= pos1;
        end
        if (state_reg == ST_TAP_B)
        begin
            s1_reg <= tap1_ok ? dram_rdata : '0;
        end
        if (state_reg == ST_TAP_C)
        begin
            s2_reg <= tap2_ok ? dram_rdata : '0;
        end
        if (state_reg == ST_WET)
        begin
            wet_reg <= wet_next;
        end
        else if (st_we)
        begin
            wet_reg <= y_sat;
        end
        if (out_load)
        begin
            out_data_reg <= mix_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign audio_out = out_data_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // Stage counter is back at the first stage whenever a new word can enter
    a_stage_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (stage_reg == '0))
        else $error("allpass stage counter not rewound at idle");

    // Fill count never passes the delay depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_BITS'(DELAY_DEPTH))
        else $error("delay fill count overflow");

    // Clamped integer delay keeps both taps inside the line
    a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAP_A) |-> (dint_reg <= ADDR_BITS'(DELAY_DEPTH - 2)))
        else $error("integer delay out of range");

    // Finishing a word presents it and moves the write index
    a_word_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && (wi_reg != $past(wi_reg))))
        else $error("finished word not presented or write index stuck");

endmodule

@@ rtl/htda_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; instantiated for the delay line and the allpass state.
module htda_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, read-first registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
